>>> hw/rtl/lsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsd_pkg;

	localparam int KIND_W = 2;
	localparam int SEED_W = 32;
	localparam int ELEM_W = 6;
	localparam int DRAW_W = 15;
	localparam int DRAW_LSB = 16;
	localparam int STEP_W = $clog2(DRAW_W);

	localparam logic [KIND_W-1:0] KIND_DEAL = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SHUFFLE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SEED = 2'd2;

	localparam logic [SEED_W-1:0] LCG_MUL = 32'd1664525;
	localparam logic [SEED_W-1:0] LCG_ADD = 32'd1013904223;
	localparam logic [SEED_W-1:0] LCG_RESET = 32'd1;

	typedef struct packed {
		logic busy;
		logic done;
	} mod_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/lsd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lsd_in_if
	import lsd_pkg::*;
	();
	logic valid;
	logic ready;
	logic [KIND_W-1:0] kind;
	logic [SEED_W-1:0] seed_value;

	modport source(output valid, kind, seed_value, input ready);
	modport sink(input valid, kind, seed_value, output ready);
endinterface

interface lsd_out_if
	import lsd_pkg::*;
	();
	logic valid;
	logic ready;
	logic [ELEM_W-1:0] element;
	logic reshuffled;

	modport source(output valid, element, reshuffled, input ready);
	modport sink(input valid, element, reshuffled, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lsd_mod_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module lsd_mod_unit
	import lsd_pkg::*;
#(
	parameter int RW = 7
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [DRAW_W-1:0] numer,
	input wire logic [RW-1:0] denom,
	output mod_stat_t stat,
	output logic [RW-1:0] rem
);

	logic busy_q;
	logic done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DRAW_W-1:0] num_q;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] den_q;
	logic [RW-1:0] trial;

	// restoring remainder, one numerator bit per cycle
	assign trial = {rem_q[RW-2:0], num_q[DRAW_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= STEP_W'(DRAW_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (busy_q) begin
			num_q <= {num_q[DRAW_W-2:0], 1'b0};
			rem_q <= (trial >= den_q) ? trial - den_q : trial;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign rem = rem_q;

endmodule

`default_nettype wire

>>> hw/rtl/lcg_shuffle_dealer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Permutation dealer. After reset the table is filled with the identity in a
// pass during which no item is taken. A deal reads the table memory, then
// loads the output register, and waits while the output is stalled.
// A shuffle, explicit or forced by a deal on an exhausted table, runs
// ENTRIES-1 iterations, each of a generator multiply and add, a run of the
// bit-serial remainder unit, and a swap through the table memory (read both,
// write each). A reseed loads the generator state while the block stays
// idle. The block takes one item at a time.
module lcg_shuffle_dealer_unit
	import lsd_pkg::*;
#(
	parameter int ENTRIES = 52
) (
	input wire logic clk,
	input wire logic arst_n,
	lsd_in_if.sink in_item,
	lsd_out_if.source out_item
);

	localparam int IW = (ENTRIES > 2) ? $clog2(ENTRIES) : 1;
	localparam int PW = $clog2(ENTRIES + 1);
	localparam int RW = IW + 1;

	localparam logic [3:0] ST_INIT = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_MUL = 4'd2;
	localparam logic [3:0] ST_ADD = 4'd3;
	localparam logic [3:0] ST_DIV = 4'd4;
	localparam logic [3:0] ST_RD = 4'd5;
	localparam logic [3:0] ST_WR_I = 4'd6;
	localparam logic [3:0] ST_WR_J = 4'd7;
	localparam logic [3:0] ST_DRD = 4'd8;
	localparam logic [3:0] ST_DOUT = 4'd9;

	logic [3:0] state_q;
	logic [SEED_W-1:0] gen_q;
	logic [SEED_W-1:0] prod_q;
	logic [SEED_W-1:0] gen_next;
	logic [PW-1:0] pos_q;
	logic [IW-1:0] i_q;
	logic [IW-1:0] j_q;
	logic deal_q;
	logic flag_q;
	logic out_valid_q;
	logic [ELEM_W-1:0] element_q;
	logic reshuffled_q;

	logic [IW-1:0] mem [ENTRIES];
	logic [IW-1:0] rd_a_q;
	logic [IW-1:0] rd_b_q;
	logic [IW-1:0] raddr_a;
	logic we;
	logic [IW-1:0] waddr;
	logic [IW-1:0] wdata;

	logic mod_start;
	logic [RW-1:0] mod_den;
	logic [RW-1:0] mod_rem;
	mod_stat_t mod_stat;

	logic accept;
	logic deliver;
	logic [IW+ELEM_W-1:0] elem_ext;

	assign gen_next = prod_q + LCG_ADD;
	assign mod_start = (state_q == ST_ADD);
	assign mod_den = {1'b0, i_q} + 1'b1;

	lsd_mod_unit #(
		.RW(RW)
	) u_mod (
		.clk(clk),
		.arst_n(arst_n),
		.start(mod_start),
		.numer(gen_next[DRAW_LSB+DRAW_W-1:DRAW_LSB]),
		.denom(mod_den),
		.stat(mod_stat),
		.rem(mod_rem)
	);

	assign in_item.ready = (state_q == ST_IDLE);
	assign accept = in_item.valid && in_item.ready;
	assign deliver = (state_q == ST_DOUT) && (!out_valid_q || out_item.ready);

	// table memory port control
	always_comb begin
		raddr_a = (state_q == ST_DRD || state_q == ST_DOUT) ? pos_q[IW-1:0] : i_q;
		we = 1'b0;
		waddr = i_q;
		wdata = i_q;
		case (state_q)
			ST_INIT: begin
				we = 1'b1;
			end
			ST_WR_I: begin
				we = 1'b1;
				wdata = rd_b_q;
			end
			ST_WR_J: begin
				we = 1'b1;
				waddr = j_q;
				wdata = rd_a_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_a_q <= mem[raddr_a];
		rd_b_q <= mem[j_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			gen_q <= LCG_RESET;
			pos_q <= '0;
			i_q <= '0;
			deal_q <= 1'b0;
		end else begin
			case (state_q)
				ST_INIT: begin
					if (i_q == IW'(ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (in_item.kind)
							KIND_DEAL: begin
								deal_q <= 1'b1;
								if (pos_q >= PW'(ENTRIES)) begin
									i_q <= IW'(ENTRIES - 1);
									state_q <= ST_MUL;
								end else begin
									state_q <= ST_DRD;
								end
							end
							KIND_SHUFFLE: begin
								deal_q <= 1'b0;
								i_q <= IW'(ENTRIES - 1);
								state_q <= ST_MUL;
							end
							KIND_SEED: begin
								gen_q <= in_item.seed_value;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					gen_q <= gen_next;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (mod_stat.done) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_WR_I;
				end
				ST_WR_I: begin
					state_q <= ST_WR_J;
				end
				ST_WR_J: begin
					if (i_q == IW'(1)) begin
						pos_q <= '0;
						state_q <= deal_q ? ST_DRD : ST_IDLE;
					end else begin
						i_q <= i_q - 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_DRD: begin
					state_q <= ST_DOUT;
				end
				ST_DOUT: begin
					if (deliver) begin
						pos_q <= pos_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// generator product, remainder capture and reshuffled flag capture
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_q <= gen_q * LCG_MUL;
		end
		if (state_q == ST_DIV && mod_stat.done) begin
			j_q <= mod_rem[IW-1:0];
		end
		if (accept) begin
			flag_q <= (pos_q >= PW'(ENTRIES));
		end
	end

	assign elem_ext = {{ELEM_W{1'b0}}, rd_a_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (deliver) begin
			out_valid_q <= 1'b1;
		end else if (out_item.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (deliver) begin
			element_q <= elem_ext[ELEM_W-1:0];
			reshuffled_q <= flag_q;
		end
	end

	assign out_item.valid = out_valid_q;
	assign out_item.element = element_q;
	assign out_item.reshuffled = reshuffled_q;

endmodule

`default_nettype wire
